@@ rtl/core/ite_pkg.sv @@
// Package for the instruction timing estimator: widths, opcode codes and timing tables.
`default_nettype none
package ite_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned NS_W   = 13;
  localparam int unsigned CYC_W  = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NS_W-1:0]   ns_t;
  typedef logic [CYC_W-1:0]  cyc_t;
  typedef logic [2:0]        mode_t;

  // Top digit (bits 15:12) codes
  localparam logic [3:0] TOP_MOV   = 4'o01;
  localparam logic [3:0] TOP_CMP   = 4'o02;
  localparam logic [3:0] TOP_BIT   = 4'o03;
  localparam logic [3:0] TOP_EIS   = 4'o07;
  localparam logic [3:0] TOP_CMPB  = 4'o12;
  localparam logic [3:0] TOP_BITB  = 4'o13;

  // Bits 15:6 / 15:9 match values for jumps
  localparam logic [9:0] OP_JMP    = 10'o0001;
  localparam logic [6:0] OP_JSR    = 7'o004;

  // Group-7 subcode (bits 11:9) for XOR
  localparam logic [2:0] EIS_XOR   = 3'o4;

  // Single-operand base codes (bits 14:6)
  localparam logic [8:0] SOP_LO    = 9'o050;
  localparam logic [8:0] SOP_NEG   = 9'o054;
  localparam logic [8:0] SOP_TST   = 9'o057;
  localparam logic [8:0] SOP_ROR   = 9'o060;
  localparam logic [8:0] SOP_ASR   = 9'o062;
  localparam logic [8:0] SOP_MFP   = 9'o065;
  localparam logic [8:0] SOP_MTP   = 9'o066;
  localparam logic [8:0] SOP_HI    = 9'o067;

  localparam logic [2:0] REG_SP    = 3'd6;
  localparam logic [2:0] REG_PC    = 3'd7;

  localparam ns_t NS_MAX = 13'd4350;

  // Addressing-mode time
  function automatic ns_t addr_ns(input mode_t m);
    ns_t r;
    case (m)
      3'd0: r = 13'd0;
      3'd1: r = 13'd300;
      3'd2: r = 13'd300;
      3'd3: r = 13'd750;
      3'd4: r = 13'd450;
      3'd5: r = 13'd900;
      3'd6: r = 13'd600;
      3'd7: r = 13'd1050;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  // Addressing-mode read count (also used as the JMP and JSR read count)
  function automatic cyc_t mode_rd_cnt(input mode_t m);
    cyc_t r;
    case (m)
      3'd0: r = 3'd0;
      3'd1: r = 3'd1;
      3'd2: r = 3'd1;
      3'd3: r = 3'd2;
      3'd4: r = 3'd1;
      3'd5: r = 3'd2;
      3'd6: r = 3'd2;
      3'd7: r = 3'd3;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // MOV execute/fetch, register source
  function automatic ns_t mov_reg_ns(input mode_t m);
    ns_t r;
    case (m)
      3'd0: r = 13'd300;
      3'd1: r = 13'd1200;
      3'd2: r = 13'd1200;
      3'd3: r = 13'd1650;
      3'd4: r = 13'd1350;
      3'd5: r = 13'd1800;
      3'd6: r = 13'd1500;
      3'd7: r = 13'd1950;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  // MOV execute/fetch, memory source
  function automatic ns_t mov_mem_ns(input mode_t m);
    ns_t r;
    case (m)
      3'd0: r = 13'd450;
      3'd1: r = 13'd1200;
      3'd2: r = 13'd1200;
      3'd3: r = 13'd1650;
      3'd4: r = 13'd1350;
      3'd5: r = 13'd1800;
      3'd6: r = 13'd1650;
      3'd7: r = 13'd2100;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  // MOV execute/fetch cycles
  function automatic cyc_t mov_cyc(input mode_t m);
    cyc_t r;
    case (m)
      3'd0: r = 3'd1;
      3'd1: r = 3'd1;
      3'd2: r = 3'd1;
      3'd3: r = 3'd2;
      3'd4: r = 3'd1;
      3'd5: r = 3'd2;
      3'd6: r = 3'd2;
      3'd7: r = 3'd3;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic ns_t jmp_ns(input mode_t m);
    ns_t r;
    case (m)
      3'd0: r = 13'd0;
      3'd1: r = 13'd900;
      3'd2: r = 13'd900;
      3'd3: r = 13'd1200;
      3'd4: r = 13'd900;
      3'd5: r = 13'd1350;
      3'd6: r = 13'd1050;
      3'd7: r = 13'd1500;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  function automatic ns_t jsr_ns(input mode_t m);
    ns_t r;
    case (m)
      3'd0: r = 13'd0;
      3'd1: r = 13'd1950;
      3'd2: r = 13'd1950;
      3'd3: r = 13'd2250;
      3'd4: r = 13'd1950;
      3'd5: r = 13'd2400;
      3'd6: r = 13'd2100;
      3'd7: r = 13'd2550;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  function automatic ns_t mtp_ns(input mode_t m);
    ns_t r;
    case (m)
      3'd0: r = 13'd900;
      3'd1: r = 13'd1650;
      3'd2: r = 13'd1650;
      3'd3: r = 13'd2100;
      3'd4: r = 13'd1800;
      3'd5: r = 13'd2250;
      3'd6: r = 13'd2100;
      3'd7: r = 13'd2550;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  function automatic cyc_t mtp_cyc(input mode_t m);
    cyc_t r;
    case (m)
      3'd0: r = 3'd1;
      3'd1: r = 3'd2;
      3'd2: r = 3'd2;
      3'd3: r = 3'd3;
      3'd4: r = 3'd2;
      3'd5: r = 3'd3;
      3'd6: r = 3'd3;
      3'd7: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ite_in_if.sv @@
// Input channel interface: one instruction word per handshake.
`default_nettype none
interface ite_in_if;
  logic                valid;
  logic                ready;
  logic [15:0]         instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ite_out_if.sv @@
// Result channel interface: time and read-cycle count per handshake.
`default_nettype none
interface ite_out_if;
  logic                valid;
  logic                ready;
  logic [12:0]         time_ns;
  logic [2:0]          rd_cnt;

  modport source (output valid, output time_ns, output rd_cnt, input ready);
  modport sink   (input valid, input time_ns, input rd_cnt, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ite_timing.sv @@
// Combinational decode of one instruction word into its time and read cycles.
`default_nettype none
module ite_timing (
  input  var ite_pkg::word_t instr_word,
  output var ite_pkg::ns_t   time_ns,
  output var ite_pkg::cyc_t  rd_cnt
);
  import ite_pkg::*;

  logic [3:0] top;
  mode_t      sm, sr, dm, dr;
  logic [8:0] base;
  logic       byte_op;
  logic       is_dbl, dbl_byte, dbl_cmp, reg_dst;
  ns_t        t;
  cyc_t       c;

  assign top     = instr_word[15:12];
  assign sm      = instr_word[11:9];
  assign sr      = instr_word[8:6];
  assign dm      = instr_word[5:3];
  assign dr      = instr_word[2:0];
  assign base    = instr_word[14:6];
  assign byte_op = instr_word[15];
  assign reg_dst = (dm == 3'd0);

  // Double-operand classes: top digit 1-6 and 9-14
  assign is_dbl   = (top != 4'd0) && (top != TOP_EIS) && (top != 4'd8) && (top != 4'd15);
  assign dbl_byte = byte_op && (top != 4'd14);
  assign dbl_cmp  = (top == TOP_CMP) || (top == TOP_BIT) ||
                    (top == TOP_CMPB) || (top == TOP_BITB);

  always_comb begin
    t = 13'd300;
    c = 3'd1;
    if (is_dbl) begin
      t = addr_ns(sm);
      c = mode_rd_cnt(sm);
      if (top == TOP_MOV) begin
        // MOV word: own table, special case for PC register destination
        if (reg_dst && (dr == REG_PC)) begin
          t = t + ((sm == 3'd0) ? 13'd600 : 13'd750);
          c = c + 3'd1;
        end else begin
          t = t + ((sm == 3'd0) ? mov_reg_ns(dm) : mov_mem_ns(dm));
          c = c + mov_cyc(dm);
        end
      end else begin
        t = t + addr_ns(dm);
        c = c + mode_rd_cnt(dm);
        if (dbl_byte && !reg_dst) t = t + 13'd150;
        if (reg_dst) begin
          t = t + ((sm == 3'd0) ? 13'd300 : 13'd450);
          c = c + ((sm == 3'd0) ? 3'd1 : 3'd2);
          if (dr == REG_PC) t = t + 13'd300;
        end else begin
          t = t + (dbl_cmp ? 13'd450 : 13'd1200);
          c = c + 3'd1;
          if ((sm == 3'd0) && (sr != 3'd0) && ((dr == REG_SP) || (dr == REG_PC)))
            t = t + 13'd150;
        end
      end
    end else if (instr_word[15:6] == OP_JMP) begin
      t = jmp_ns(dm);
      c = mode_rd_cnt(dm);
    end else if (instr_word[15:9] == OP_JSR) begin
      t = jsr_ns(dm);
      c = mode_rd_cnt(dm);
    end else if (top == TOP_EIS) begin
      // XOR vs. multiply/divide/shift group
      if (sm == EIS_XOR) t = addr_ns(dm) + (reg_dst ? 13'd300 : 13'd1200);
      else               t = addr_ns(dm) + 13'd3300;
      c = mode_rd_cnt(dm) + 3'd1;
    end else if (base == SOP_MFP) begin
      t = addr_ns(dm) + 13'd1500;
      c = mode_rd_cnt(dm) + 3'd1;
    end else if (base == SOP_MTP) begin
      t = mtp_ns(dm);
      c = mtp_cyc(dm);
    end else if ((base >= SOP_LO) && (base <= SOP_HI)) begin
      // Single operand
      t = addr_ns(dm);
      if (byte_op && !reg_dst) t = t + 13'd150;
      if (base == SOP_NEG) begin
        t = t + (reg_dst ? 13'd750 : 13'd1500);
      end else if (base == SOP_TST) begin
        t = t + (reg_dst ? 13'd300 : 13'd450);
      end else begin
        t = t + (reg_dst ? 13'd300 : 13'd1200);
        if (reg_dst && (dr == REG_PC)) t = t + 13'd300;
        if (((base == SOP_ROR) || (base == SOP_ASR)) && !reg_dst && byte_op)
          t = t + 13'd150;
      end
      c = mode_rd_cnt(dm) + 3'd1;
    end
  end

  assign time_ns = t;
  assign rd_cnt  = c;

endmodule
`default_nettype wire

@@ rtl/core/instruction_timing_estimator_top.sv @@
// Top level: input register, timing decode and result register with flow control.
// Path: input register, combinational decode, result register driving out_chan.
// Throughput: one word per cycle, set by the two-stage pipe; while a result waits
// unread, the input register holds one more word and then the input stalls.
// Reset: synchronous active-low rst_n clears both stage valid flags; data
// registers are not reset.
`default_nettype none
module instruction_timing_estimator_top (
  input  wire        clk,
  input  wire        rst_n,
  ite_in_if.sink     in_chan,
  ite_out_if.source  out_chan
);
  import ite_pkg::*;

  logic   s1_v_r, s1_v_nxt;
  word_t  s1_word_r;
  logic   s2_v_r, s2_v_nxt;
  ns_t    s2_ns_r;
  cyc_t   s2_cyc_r;
  ns_t    dec_ns;
  cyc_t   dec_cyc;
  logic   s2_load, s1_load;

  // Stage advance
  assign s2_load = s1_v_r && (!s2_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || s2_load;
  assign s1_load = in_chan.valid && in_chan.ready;

  assign s1_v_nxt = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_v_r);
  assign s2_v_nxt = s2_load ? 1'b1 : ((s2_v_r && out_chan.ready) ? 1'b0 : s2_v_r);

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Input word register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_chan.instr_word;
    end
  end

  ite_timing u_timing (
    .instr_word (s1_word_r),
    .time_ns    (dec_ns),
    .rd_cnt     (dec_cyc)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_ns_r  <= dec_ns;
      s2_cyc_r <= dec_cyc;
    end
  end

  assign out_chan.valid   = s2_v_r;
  assign out_chan.time_ns = s2_ns_r;
  assign out_chan.rd_cnt  = s2_cyc_r;

  // Checks
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_v_r && !s2_v_r) |-> in_chan.ready)
    else $error("empty pipe not ready");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && (!s2_v_r || out_chan.ready)) |=> s2_v_r)
    else $error("stage 1 word did not advance");

  a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> ((s2_cyc_r == 3'd0) == (s2_ns_r == 13'd0)))
    else $error("zero time and zero cycles disagree");

  a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (s2_ns_r <= NS_MAX))
    else $error("time out of range");

endmodule
`default_nettype wire
